[sv/a2rm_pkg.sv]
// Package: shared types, constants and fixed-point helpers for the rotation block.
`timescale 1ns / 1ps
package a2rm_pkg;

  localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PI_HALF_Q62 = 64'h6487_ED51_10B4_611A;
  localparam int unsigned TAYLOR_TERMS = 12;
  localparam int unsigned OUT_W        = 18;
  localparam int unsigned IN_W         = 16;

  // Per-item trig state for the three angles (0: heading+azimuth, 1: elevation, 2: roll).
  typedef struct packed {
    logic [2:0][63:0] x;
    logic [2:0][63:0] x2;
    logic [2:0][63:0] hs;
    logic [2:0][63:0] hc;
    logic [2:0][1:0]  q;
  } trig_t;

  // 1 - t, floored at zero.
  function automatic logic [63:0] one_minus(input logic [63:0] t);
    return (t >= ONE_Q62) ? 64'd0 : ONE_Q62 - t;
  endfunction

endpackage

[sv/a2rm_if.sv]
// Interfaces: angle input channel and matrix output channel.
`timescale 1ns / 1ps
interface a2rm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] azimuth;
  logic [15:0] heading;
  logic [15:0] elevation;
  logic [15:0] roll_angle;
  modport source (output valid, azimuth, heading, elevation, roll_angle, input ready);
  modport sink   (input valid, azimuth, heading, elevation, roll_angle, output ready);
endinterface

interface a2rm_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] rot_0;
  logic signed [17:0] rot_1;
  logic signed [17:0] rot_2;
  logic signed [17:0] rot_3;
  logic signed [17:0] rot_4;
  logic signed [17:0] rot_5;
  logic signed [17:0] rot_6;
  logic signed [17:0] rot_7;
  logic signed [17:0] rot_8;
  modport source (output valid, rot_0, rot_1, rot_2, rot_3, rot_4, rot_5, rot_6, rot_7,
                  rot_8, input ready);
  modport sink   (input valid, rot_0, rot_1, rot_2, rot_3, rot_4, rot_5, rot_6, rot_7,
                  rot_8, output ready);
endinterface

[sv/a2rm_cell.sv]
// Taylor cell (one Horner step for all three angles) and its pipelined 64x64 multiplier.
`timescale 1ns / 1ps
module a2rm_mul64 (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic [127:0] p_o
);
  // Four 32x32 partial products are registered, then their sum is registered.
  logic [63:0]  ll_d, lh_d, hl_d, hh_d;
  logic [63:0]  ll_q, lh_q, hl_q, hh_q;
  logic [127:0] p_d, p_q;

  assign ll_d = {32'd0, a_i[31:0]}  * {32'd0, b_i[31:0]};
  assign lh_d = {32'd0, a_i[31:0]}  * {32'd0, b_i[63:32]};
  assign hl_d = {32'd0, a_i[63:32]} * {32'd0, b_i[31:0]};
  assign hh_d = {32'd0, a_i[63:32]} * {32'd0, b_i[63:32]};
  assign p_d  = {hh_q, ll_q} + {32'd0, lh_q, 32'd0} + {32'd0, hl_q, 32'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      hh_q <= hh_d;
      p_q  <= p_d;
    end
  end

  assign p_o = p_q;
endmodule

module a2rm_cell #(
  parameter int unsigned K = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  a2rm_pkg::trig_t d_i,
  output logic            vld_o,
  output a2rm_pkg::trig_t d_o
);
  import a2rm_pkg::*;

  localparam int unsigned DivS = (2 * K) * (2 * K + 1);
  localparam int unsigned DivC = (2 * K - 1) * (2 * K);
  localparam int unsigned ShS  = $clog2(DivS);
  localparam int unsigned ShC  = $clog2(DivC);
  // ceil(2^(64+sh)/div); bit 64 is always set and is folded in as "+ n".
  localparam logic [127:0] RecS =
    ((128'd1 << (64 + ShS)) + 128'(DivS) - 128'd1) / 128'(DivS);
  localparam logic [127:0] RecC =
    ((128'd1 << (64 + ShC)) + 128'(DivC) - 128'd1) / 128'(DivC);
  localparam logic [63:0]  RecSLo = RecS[63:0];
  localparam logic [63:0]  RecCLo = RecC[63:0];

  // Steps: x2*h product, reciprocal product, then quotient and 1 - q, each registered.
  trig_t a1_q, a2_q, b1_q, b2_q, d_d, d_q;
  logic [4:0] vld_q;
  logic [2:0][63:0]  ns_a, nc_a, ns1_q, nc1_q, ns2_q, nc2_q;
  logic [2:0][127:0] ps_a, pc_a, ps_b, pc_b;

  for (genvar i = 0; i < 3; i++) begin : g_ang
    a2rm_mul64 u_mul_sa (
      .clk_i(clk_i),
      .en_i (en_i),
      .a_i  (d_i.x2[i]),
      .b_i  (d_i.hs[i]),
      .p_o  (ps_a[i])
    );
    a2rm_mul64 u_mul_ca (
      .clk_i(clk_i),
      .en_i (en_i),
      .a_i  (d_i.x2[i]),
      .b_i  (d_i.hc[i]),
      .p_o  (pc_a[i])
    );
    assign ns_a[i] = ps_a[i][125:62];
    assign nc_a[i] = pc_a[i][125:62];
    a2rm_mul64 u_mul_sb (
      .clk_i(clk_i),
      .en_i (en_i),
      .a_i  (ns_a[i]),
      .b_i  (RecSLo),
      .p_o  (ps_b[i])
    );
    a2rm_mul64 u_mul_cb (
      .clk_i(clk_i),
      .en_i (en_i),
      .a_i  (nc_a[i]),
      .b_i  (RecCLo),
      .p_o  (pc_b[i])
    );
  end

  always_comb begin
    logic [64:0] qs, qc;
    d_d = b2_q;
    for (int i = 0; i < 3; i++) begin
      qs = (65'(ns2_q[i]) + 65'(ps_b[i][127:64])) >> ShS;
      qc = (65'(nc2_q[i]) + 65'(pc_b[i][127:64])) >> ShC;
      d_d.hs[i] = one_minus(qs[63:0]);
      d_d.hc[i] = one_minus(qc[63:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= d_i;
      a2_q  <= a1_q;
      b1_q  <= a2_q;
      b2_q  <= b1_q;
      d_q   <= d_d;
      ns1_q <= ns_a;
      nc1_q <= nc_a;
      ns2_q <= ns1_q;
      nc2_q <= nc1_q;
    end
  end

  assign vld_o = vld_q[4];
  assign d_o   = d_q;
endmodule

[sv/angles_to_rotation_matrix_top.sv]
// Top level: camera angles to 3x3 rotation matrix, fully pipelined.
//
//  channel | dir | payload                                   | handshake
//  in_i    | in  | azimuth, heading, elevation, roll_angle   | valid/ready
//  out_o   | out | rot_0 .. rot_8 (signed Q.FRAC_BITS)       | valid/ready
//
// One item per cycle when out_o does not stall. Stages: front (x, then x squared over
// the pipelined multiplier); 12 Taylor cells; the sine product; quadrant/round;
// 2 matrix stages. The Taylor cell chain sets the depth.
// Reset clears only the valid bits. A stall on out_o freezes the whole pipe
// through one common enable, so no beat is lost or repeated.
`timescale 1ns / 1ps
module angles_to_rotation_matrix_top #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  a2rm_in_if.sink       in_i,
  a2rm_out_if.source    out_o
);
  import a2rm_pkg::*;

  localparam int unsigned AB = ANGLE_BITS;
  localparam int unsigned QB = ANGLE_BITS - 2;
  localparam int unsigned W  = FRAC_BITS + 2;     // sin/cos and entries
  localparam int unsigned PW = 2 * W + 1;         // product sums
  localparam logic [63:0] HALF = 64'd1 << (61 - FRAC_BITS);
  localparam logic signed [PW:0] RHALF = (PW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW:0] RLIM  = (PW + 1)'(1) << FRAC_BITS;

  // Round to nearest and saturate to +-1.0.
  function automatic logic signed [W-1:0] rnd(input logic signed [PW-1:0] v);
    logic signed [PW:0] a;
    logic signed [PW:0] r;
    a = (PW + 1)'(v) + RHALF;
    r = a >>> FRAC_BITS;
    if (r > RLIM) r = RLIM;
    if (r < -RLIM) r = -RLIM;
    return r[W-1:0];
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [2*W-1:0] p;
    p = a * b;
    return PW'(p);
  endfunction

  function automatic logic [OUT_W-1:0] pack(input logic signed [W-1:0] v);
    logic signed [W+OUT_W-1:0] e;
    e = (W + OUT_W)'(v);
    return e[OUT_W-1:0];
  endfunction

  // Common advance: the output register empties or is taken.
  logic en;
  logic out_vld_q;
  assign en        = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // ---------------- front stage 1: angle wrap, quadrant, x = frac * pi/2
  logic [AB+IN_W:0] az_w, hd_w, el_w, rl_w, h_w;
  logic [2:0][AB-1:0] ang;
  trig_t f1_d, f1_q, f2a_q, f2_q, f2_d;
  logic  f1_vld_q, f2a_vld_q, f2_vld_q;
  logic [2:0][127:0] x2_p;

  always_comb begin
    logic [QB+31:0] plo, phi;
    logic [QB+63:0] prod;
    az_w = (AB + IN_W + 1)'(in_i.azimuth);
    hd_w = (AB + IN_W + 1)'(in_i.heading);
    el_w = (AB + IN_W + 1)'(in_i.elevation);
    rl_w = (AB + IN_W + 1)'(in_i.roll_angle);
    h_w  = az_w + hd_w;
    ang[0] = h_w[AB-1:0];
    ang[1] = el_w[AB-1:0];
    ang[2] = rl_w[AB-1:0];
    f1_d = '0;
    for (int i = 0; i < 3; i++) begin
      // narrow angle times the 64-bit constant, as two 32-bit halves
      plo  = (QB + 32)'(ang[i][QB-1:0]) * (QB + 32)'(PI_HALF_Q62[31:0]);
      phi  = (QB + 32)'(ang[i][QB-1:0]) * (QB + 32)'(PI_HALF_Q62[63:32]);
      prod = (QB + 64)'(plo) + {phi, 32'd0};
      f1_d.x[i] = prod[QB+63:QB];
      f1_d.q[i] = ang[i][AB-1:AB-2];
    end
  end

  // ---------------- front stages 2-3: x squared, series seeds
  for (genvar i = 0; i < 3; i++) begin : g_sq
    a2rm_mul64 u_sq (
      .clk_i(clk_i),
      .en_i (en),
      .a_i  (f1_q.x[i]),
      .b_i  (f1_q.x[i]),
      .p_o  (x2_p[i])
    );
  end

  always_comb begin
    f2_d = f2_q;
    for (int i = 0; i < 3; i++) begin
      f2_d.x2[i] = x2_p[i][125:62];
      f2_d.hs[i] = ONE_Q62;
      f2_d.hc[i] = ONE_Q62;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q  <= 1'b0;
      f2a_vld_q <= 1'b0;
      f2_vld_q  <= 1'b0;
    end else if (en) begin
      f1_vld_q  <= in_i.valid;
      f2a_vld_q <= f1_vld_q;
      f2_vld_q  <= f2a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q  <= f1_d;
      f2a_q <= f1_q;
      f2_q  <= f2a_q;
    end
  end

  // ---------------- Taylor cell chain, highest term first
  trig_t cd [TAYLOR_TERMS+1];
  logic  cv [TAYLOR_TERMS+1];
  assign cd[0] = f2_d;
  assign cv[0] = f2_vld_q;

  for (genvar g = 0; g < TAYLOR_TERMS; g++) begin : g_cell
    a2rm_cell #(.K(TAYLOR_TERMS - g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (cv[g]),
      .d_i   (cd[g]),
      .vld_o (cv[g+1]),
      .d_o   (cd[g+1])
    );
  end

  // sine product x * hs over the pipelined multiplier
  trig_t u1_q, u2_q;
  logic  u1_vld_q, u2_vld_q;
  logic [2:0][127:0] s_p;

  for (genvar i = 0; i < 3; i++) begin : g_sin
    a2rm_mul64 u_sin (
      .clk_i(clk_i),
      .en_i (en),
      .a_i  (cd[TAYLOR_TERMS].x[i]),
      .b_i  (cd[TAYLOR_TERMS].hs[i]),
      .p_o  (s_p[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_q <= cd[TAYLOR_TERMS];
      u2_q <= u1_q;
    end
  end

  // ---------------- quadrant unfold and rounding to Q.FRAC_BITS
  logic signed [W-1:0] sn_d [3], cs_d [3], sn_q [3], cs_q [3];
  logic sc_vld_q;

  always_comb begin
    logic [63:0] s, sr, cr;
    logic signed [W-1:0] sv, cv2;
    for (int i = 0; i < 3; i++) begin
      s   = s_p[i][125:62];
      sr  = (s + HALF) >> (62 - FRAC_BITS);
      cr  = (u2_q.hc[i] + HALF) >> (62 - FRAC_BITS);
      sv  = sr[W-1:0];
      cv2 = cr[W-1:0];
      case (u2_q.q[i])
        2'd0:    begin sn_d[i] = sv;   cs_d[i] = cv2;  end
        2'd1:    begin sn_d[i] = cv2;  cs_d[i] = -sv;  end
        2'd2:    begin sn_d[i] = -sv;  cs_d[i] = -cv2; end
        default: begin sn_d[i] = -cv2; cs_d[i] = sv;   end
      endcase
    end
  end

  // ---------------- matrix stage 1: single products, t and u
  logic signed [W-1:0]  t_q, u_q, r1_q, r4_q, r6_q, r7_q, r8_q, sr_q, cr_q;
  logic signed [PW-1:0] chcr_q, shcr_q, chsr_q, shsr_q;
  logic m1_vld_q;

  // ---------------- matrix stage 2: output register
  logic [OUT_W-1:0] o_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u1_vld_q  <= 1'b0;
      u2_vld_q  <= 1'b0;
      sc_vld_q  <= 1'b0;
      m1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      u1_vld_q  <= cv[TAYLOR_TERMS];
      u2_vld_q  <= u1_vld_q;
      sc_vld_q  <= u2_vld_q;
      m1_vld_q  <= sc_vld_q;
      out_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn_q <= sn_d;
      cs_q <= cs_d;
      // stage 1
      t_q    <= rnd(mul(sn_q[0], sn_q[1]));
      u_q    <= rnd(mul(cs_q[0], sn_q[1]));
      r1_q   <= rnd(mul(cs_q[1], sn_q[2]));
      r4_q   <= rnd(mul(cs_q[1], cs_q[2]));
      r6_q   <= rnd(mul(sn_q[0], cs_q[1]));
      r7_q   <= -sn_q[1];
      r8_q   <= rnd(mul(cs_q[0], cs_q[1]));
      chcr_q <= mul(cs_q[0], cs_q[2]);
      shcr_q <= mul(sn_q[0], cs_q[2]);
      chsr_q <= mul(cs_q[0], sn_q[2]);
      shsr_q <= mul(sn_q[0], sn_q[2]);
      sr_q   <= sn_q[2];
      cr_q   <= cs_q[2];
      // stage 2
      o_q[0] <= pack(rnd(chcr_q + mul(t_q, sr_q)));
      o_q[1] <= pack(r1_q);
      o_q[2] <= pack(rnd(mul(u_q, sr_q) - shcr_q));
      o_q[3] <= pack(rnd(mul(t_q, cr_q) - chsr_q));
      o_q[4] <= pack(r4_q);
      o_q[5] <= pack(rnd(shsr_q + mul(u_q, cr_q)));
      o_q[6] <= pack(r6_q);
      o_q[7] <= pack(r7_q);
      o_q[8] <= pack(r8_q);
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.rot_0 = o_q[0];
  assign out_o.rot_1 = o_q[1];
  assign out_o.rot_2 = o_q[2];
  assign out_o.rot_3 = o_q[3];
  assign out_o.rot_4 = o_q[4];
  assign out_o.rot_5 = o_q[5];
  assign out_o.rot_6 = o_q[6];
  assign out_o.rot_7 = o_q[7];
  assign out_o.rot_8 = o_q[8];

`ifndef SYNTHESIS
  // A held result blocks intake, so nothing is overwritten.
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while output stalled");

  // An accepted beat enters the first front stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> f1_vld_q)
    else $error("accepted beat lost at pipe entry");

  // The quadrant and matrix stage 1 valid bits hold still across a stall.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(sc_vld_q) && $stable(m1_vld_q)))
    else $error("pipe moved during stall");
`endif
endmodule

[dv/angles_to_rotation_matrix_top_test.sv]
// Testbench for angles_to_rotation_matrix_top: angle sets in, checked 3x3 matrices out.
`timescale 1ns / 1ps
module angles_to_rotation_matrix_top_test;

  // Nine signed Q1.16 entries, row-major.
  typedef struct packed {
    logic [8:0][17:0] rot;
  } matrix_t;

  logic clk_i;
  logic rst_ni;

  a2rm_in_if  in_ch ();
  a2rm_out_if out_ch ();

  angles_to_rotation_matrix_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  matrix_t matrix_q[$];   // matrices still owed by the block
  int      mismatches;
  int      burst_left;
  int      quiet_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Matrix predictor
  // ---------------------------------------------------------------------------

  // (a*b) >> s over the full 128-bit product.
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b,
                                          input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> s);
  endfunction

  function automatic logic [63:0] floor_one_minus(input logic [63:0] t);
    return (t >= a2rm_pkg::ONE_Q62) ? 64'd0 : a2rm_pkg::ONE_Q62 - t;
  endfunction

  // Sine and cosine of a 16-bit binary angle, rounded to signed Q.16.
  task automatic angle_trig(input logic [15:0] ang, output longint sn, output longint cs);
    logic [63:0] x, x2, hs, hc, s_q, c_q;
    longint      s_r, c_r;
    x  = q62_mul({50'd0, ang[13:0]}, a2rm_pkg::PI_HALF_Q62, 14);
    x2 = q62_mul(x, x, 62);
    hs = a2rm_pkg::ONE_Q62;
    hc = a2rm_pkg::ONE_Q62;
    for (int k = a2rm_pkg::TAYLOR_TERMS; k >= 1; k--) begin
      hs = floor_one_minus(q62_mul(x2, hs, 62) / 64'((2 * k) * (2 * k + 1)));
      hc = floor_one_minus(q62_mul(x2, hc, 62) / 64'((2 * k - 1) * (2 * k)));
    end
    s_q = q62_mul(x, hs, 62);
    c_q = hc;
    s_r = longint'((s_q + (64'd1 << 45)) >> 46);
    c_r = longint'((c_q + (64'd1 << 45)) >> 46);
    // quadrant symmetry
    case (ang[15:14])
      2'd0: begin sn = s_r;  cs = c_r;  end
      2'd1: begin sn = c_r;  cs = -s_r; end
      2'd2: begin sn = -s_r; cs = -c_r; end
      default: begin sn = -c_r; cs = s_r; end
    endcase
  endtask

  // Round-to-nearest back to Q.16, floor semantics, saturated to +-1.0.
  function automatic longint round_q16(input longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 65536) r = 65536;
    if (r < -65536) r = -65536;
    return r;
  endfunction

  task automatic predict_matrix(input logic [15:0] az, input logic [15:0] hd,
                                input logic [15:0] el, input logic [15:0] rl,
                                output matrix_t m);
    longint sh, ch, se, ce, sr, cr, t, u;
    logic [15:0] h;
    h = az + hd;   // wraps at one turn
    angle_trig(h, sh, ch);
    angle_trig(el, se, ce);
    angle_trig(rl, sr, cr);
    t = round_q16(sh * se);
    u = round_q16(ch * se);
    m.rot[0] = 18'(round_q16(ch * cr + t * sr));
    m.rot[1] = 18'(round_q16(ce * sr));
    m.rot[2] = 18'(round_q16(u * sr - sh * cr));
    m.rot[3] = 18'(round_q16(t * cr - ch * sr));
    m.rot[4] = 18'(round_q16(ce * cr));
    m.rot[5] = 18'(round_q16(sh * sr + u * cr));
    m.rot[6] = 18'(round_q16(sh * ce));
    m.rot[7] = 18'(-se);
    m.rot[8] = 18'(round_q16(ch * ce));
  endtask

  // ---------------------------------------------------------------------------
  // Angle sender: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  task automatic send_angles(input logic [15:0] az, input logic [15:0] hd,
                             input logic [15:0] el, input logic [15:0] rl);
    matrix_t m;
    if (burst_left == 0) begin
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 20);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.azimuth    <= az;
    in_ch.heading    <= hd;
    in_ch.elevation  <= el;
    in_ch.roll_angle <= rl;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_matrix(az, hd, el, rl, m);
    matrix_q.push_back(m);
  endtask

  task automatic idle_sender();
    in_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Matrix checker and receiver stall pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      matrix_t got, want;
      got.rot = {out_ch.rot_8, out_ch.rot_7, out_ch.rot_6, out_ch.rot_5, out_ch.rot_4,
                 out_ch.rot_3, out_ch.rot_2, out_ch.rot_1, out_ch.rot_0};
      if (matrix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected matrix beat %h", got);
      end else begin
        want = matrix_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got.rot[i] !== want.rot[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("rot_%0d mismatch: expected %0d, got %0d", i,
                       $signed(want.rot[i]), $signed(got.rot[i]));
          end
        end
      end
    end
    // receiver: long open stretches, then stretches of random stalls
    if (quiet_left > 0) begin
      quiet_left--;
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 99) == 0) begin
      quiet_left = $urandom_range(20, 120);
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, quadrant boundaries and heading+azimuth wrap.
  task automatic test_directed();
    send_angles(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_angles(16'h0000, 16'h4000, 16'h4000, 16'h4000);
    send_angles(16'h0000, 16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h0000, 16'hC000, 16'hC000, 16'hC000);
    send_angles(16'h3FFF, 16'h0000, 16'h3FFF, 16'h7FFF);
    send_angles(16'hBFFF, 16'h0000, 16'hFFFF, 16'hC001);
    send_angles(16'h8000, 16'h8000, 16'h2000, 16'h6000);  // sum wraps to zero
    send_angles(16'hFFFF, 16'h0001, 16'hE000, 16'hA000);  // sum wraps to zero
    send_angles(16'hC000, 16'h8000, 16'h0001, 16'hFFFF);
    send_angles(16'h1234, 16'hFEDC, 16'h5555, 16'hAAAA);
    send_angles(16'h2000, 16'h2000, 16'h4001, 16'h3FFF);
    send_angles(16'hAAAA, 16'h5555, 16'h0000, 16'h8001);
  endtask

  function automatic logic [15:0] pick_angle();
    // mix of uniform angles and angles near quadrant boundaries
    if ($urandom_range(0, 4) == 0)
      return {2'($urandom_range(0, 3)), 14'd0} + 16'($urandom_range(0, 4)) - 16'd2;
    return 16'($urandom);
  endfunction

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++)
      send_angles(pick_angle(), pick_angle(), pick_angle(), pick_angle());
  endtask

  // Sender holds off until the pipe has fully drained.
  task automatic test_drain_pause();
    idle_sender();
    wait (matrix_q.size() == 0);
    @(posedge clk_i);
    test_random(50);
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.azimuth    = '0;
    in_ch.heading    = '0;
    in_ch.elevation  = '0;
    in_ch.roll_angle = '0;
    out_ch.ready     = 1'b0;
    mismatches       = 0;
    burst_left       = 0;
    quiet_left       = 0;
    rst_ni           = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(800);
    test_drain_pause();
    test_random(800);

    idle_sender();
    wait (matrix_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && matrix_q.size() == 0) begin
      $display("angles_to_rotation_matrix_top verification clean");
    end else begin
      $display("angles_to_rotation_matrix_top verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("angles_to_rotation_matrix_top verification failed");
    $finish;
  end

endmodule
